// ----- rtl/integer_to_ascii_converter_defines.svh -----
// Assertion macros for the integer to ASCII converter.
// Each macro expects signals named clk and rst_n in scope.
`ifndef INTEGER_TO_ASCII_CONVERTER_DEFINES_SVH
`define INTEGER_TO_ASCII_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Consequent holds in the same cycle as the antecedent.
`define ITOA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

`else

`define ITOA_ASSERT_SAME(lbl, ante, cons)
`define ITOA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/itoa_pkg.sv -----
`default_nettype none

package itoa_pkg;

  localparam int NUMBER_WIDTH = 32;

  typedef struct packed {
    logic signed [NUMBER_WIDTH-1:0] number;
    logic                           hex_mode;
  } in_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
    logic push_sign;
    logic push_digit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bit_last;
    logic neg;
    logic lead_zero;
    logic cnt_one;
    logic out_free;
  } sts_t;

  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  localparam logic [6:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itoa_ctrl.sv -----
`default_nettype none

module itoa_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_hex,
  output logic              in_stall,
  input  wire itoa_pkg::sts_t sts,
  output itoa_pkg::cmd_t    cmd
);
  import itoa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_hex ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (sts.bit_last) begin
          state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) begin
          cmd.push_sign = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // drop leading zeros without a beat, but always send the final digit
        if (sts.lead_zero && !sts.cnt_one) begin
          cmd.shift = 1'b1;
        end else if (sts.out_free) begin
          cmd.shift      = 1'b1;
          cmd.push_digit = 1'b1;
          if (sts.cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/itoa_dpath.sv -----
`default_nettype none

module itoa_dpath #(
  parameter int NUMBER_WIDTH = 32,
  parameter int DIGITS       = 10,
  parameter int HEX_DIGITS   = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire itoa_pkg::cmd_t cmd,
  output itoa_pkg::sts_t      sts,
  input  wire itoa_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output itoa_pkg::out_t      out_data
);
  import itoa_pkg::*;

  localparam int DIG_W = 4 * DIGITS;
  localparam int CNT_W = $clog2(DIGITS + 1);
  localparam int BIT_W = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;
  localparam int HEX_SHIFT = 4 * (DIGITS - HEX_DIGITS);

  logic [NUMBER_WIDTH-1:0] bin_r, bin_nxt;
  logic [DIG_W-1:0]        dig_r, dig_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [BIT_W-1:0]        bit_r, bit_nxt;
  logic                    neg_r, neg_nxt;
  logic                    started_r, started_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r, out_nxt;

  logic [NUMBER_WIDTH-1:0] raw;
  logic [NUMBER_WIDTH-1:0] mag;
  logic                    neg_in;
  logic [DIG_W-1:0]        adj;
  logic [3:0]              top_digit;
  logic                    out_free;

  assign raw    = NUMBER_WIDTH'(in_data.number);
  assign neg_in = !in_data.hex_mode && raw[NUMBER_WIDTH-1];
  assign mag    = neg_in ? (~raw + NUMBER_WIDTH'(1)) : raw;

  // add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3
                                                 : dig_r[4*i +: 4];
    end
  end

  assign top_digit = dig_r[DIG_W-1 -: 4];
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    bin_nxt     = bin_r;
    dig_nxt     = dig_r;
    cnt_nxt     = cnt_r;
    bit_nxt     = bit_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    out_nxt     = out_r;

    if (cmd.load) begin
      bin_nxt     = mag;
      neg_nxt     = neg_in;
      started_nxt = 1'b0;
      bit_nxt     = '0;
      if (in_data.hex_mode) begin
        // left-align the hex digits so the top nibble leads
        dig_nxt = DIG_W'(mag) << HEX_SHIFT;
        cnt_nxt = CNT_W'(HEX_DIGITS);
      end else begin
        dig_nxt = '0;
        cnt_nxt = CNT_W'(DIGITS);
      end
    end

    if (cmd.dabble) begin
      dig_nxt = {adj[DIG_W-2:0], bin_r[NUMBER_WIDTH-1]};
      bin_nxt = bin_r << 1;
      bit_nxt = bit_r + BIT_W'(1);
    end

    if (cmd.shift) begin
      dig_nxt = dig_r << 4;
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    if (cmd.push_sign) begin
      out_nxt.character = CHAR_MINUS;
      out_nxt.last      = 1'b0;
    end

    if (cmd.push_digit) begin
      out_nxt.character = digit_char(top_digit);
      out_nxt.last      = (cnt_r == CNT_W'(1));
      started_nxt       = 1'b1;
    end
  end

  assign out_valid_nxt = (cmd.push_sign || cmd.push_digit) ? 1'b1
                                                           : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    dig_r     <= dig_nxt;
    cnt_r     <= cnt_nxt;
    bit_r     <= bit_nxt;
    neg_r     <= neg_nxt;
    started_r <= started_nxt;
    out_r     <= out_nxt;
  end

  assign sts.bit_last  = (bit_r == BIT_W'(NUMBER_WIDTH - 1));
  assign sts.neg       = neg_r;
  assign sts.lead_zero = (top_digit == 4'd0) && !started_r;
  assign sts.cnt_one   = (cnt_r == CNT_W'(1));
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/integer_to_ascii_converter.sv -----
// Channel  Dir  Payload                          Handshake
// in_      in   number (s32), hex_mode (1)       in_valid / in_stall
// out_     out  character (7), last (1)          out_valid / out_stall
//
// One item at a time. Decimal: a load, one shift-add-3 step per input bit in
// the BCD converter, a minus sign if negative, then one step per digit
// position (leading zeros are dropped one per cycle without an output beat).
// Hex: a load, then one step per nibble.
// in_stall is high from acceptance until the last character is in the output
// register; a held last beat does not block the next item.
// rst_n is synchronous and clears the controller and the output valid.
// out_stall holds the output register and pauses digit emission.
`default_nettype none

`include "integer_to_ascii_converter_defines.svh"

module integer_to_ascii_converter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire itoa_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output itoa_pkg::out_t      out_data
);
  import itoa_pkg::*;

  // ceil(NUMBER_WIDTH * log10(2)) decimal digits, ceil(NUMBER_WIDTH / 4) hex digits
  localparam int DIGITS     = (NUMBER_WIDTH * 30103 + 99999) / 100000;
  localparam int HEX_DIGITS = (NUMBER_WIDTH + 3) / 4;

  cmd_t cmd;
  sts_t sts;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_hex   (in_data.hex_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_dpath #(
    .NUMBER_WIDTH (NUMBER_WIDTH),
    .DIGITS       (DIGITS),
    .HEX_DIGITS   (HEX_DIGITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ITOA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ITOA_ASSERT_SAME(a_push_needs_room, cmd.push_sign || cmd.push_digit, sts.out_free)
  `ITOA_ASSERT_NEXT(a_idle_after_last, cmd.push_digit && sts.cnt_one, !in_stall)

endmodule

`default_nettype wire
